[src/trial_division_prime_test_macros.svh]
// assertion macros for the trial division prime test
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define TDPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen outside reset
`define TDPT_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TDPT_ASSERT(label, clk, rst, prop, msg)
`define TDPT_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[src/tdpt_pkg.sv]
// shared types and constants for the trial division prime test
package tdpt_pkg;

   localparam int NUMBER_BITS   = 32;
   localparam int CNT_BITS      = $clog2(NUMBER_BITS);
   localparam int REQ_DATA_BITS = ((NUMBER_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 8;

   typedef logic [NUMBER_BITS-1:0]   number_type;
   typedef logic [REQ_DATA_BITS-1:0] req_data_type;
   typedef logic [RSP_DATA_BITS-1:0] rsp_data_type;
   typedef logic [CNT_BITS-1:0]      cnt_type;

   localparam number_type SMALL_LIMIT   = number_type'(1);
   localparam number_type TINY_PRIME    = number_type'(3);
   localparam number_type FIRST_DIVISOR = number_type'(5);
   localparam number_type PAIR_OFFSET   = number_type'(2);
   localparam number_type DIVISOR_STEP  = number_type'(6);
   localparam cnt_type    CNT_LAST      = cnt_type'(NUMBER_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV3,
      ST_DIVD,
      ST_DIVD2,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic       start;
      number_type divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      number_type quotient;
      number_type remainder;
   } div_rsp_type;

   typedef struct packed {
      logic load;
      logic is_prime;
   } seq_res_type;

endpackage

[src/trial_division_prime_test.sv]
// top level of the trial division prime test
// tests one unsigned 32-bit number per beat for primality by trial division:
// 0 and 1 give 0, 2 and 3 give 1, other even numbers give 0 at once; odd
// numbers are divided by 3 and then by d and d+2 for d = 5, 11, 17, ...
// until d exceeds n / d. every division runs on one shared restoring divider
// that produces one quotient bit per clock.
// work: trivial values skip the divider and go straight to the done state;
// other numbers need D divisions, where a prime that survives k divisor
// pairs needs D = 2 + 2k; the worst case, a prime near 2^32, runs about
// 21.8k divisions, close to 2 * sqrt(n) / 6.
// one number is worked on at a time and req_tready is high only while the
// sequencer is idle; the answer sits in an output register, so the next
// number can be taken while a result still waits on rsp_tready
module trial_division_prime_test (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tdpt_pkg::req_data_type req_tdata,   // [31:0] number
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output tdpt_pkg::rsp_data_type rsp_tdata    // [0] is_prime, [7:1] zero
);
   import tdpt_pkg::*;

`include "trial_division_prime_test_macros.svh"

   logic        seq_idle;
   logic        slot_free;
   seq_res_type seq_res;
   div_req_type div_req;
   div_rsp_type div_rsp;
   number_type  dividend;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_prime_ff;

   // output slot can take a result when empty or being drained this cycle
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = seq_idle;

   tdpt_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && req_tready),
      .number    (req_tdata[NUMBER_BITS-1:0]),
      .idle      (seq_idle),
      .slot_free (slot_free),
      .seq_res   (seq_res),
      .div_req   (div_req),
      .dividend  (dividend),
      .div_rsp   (div_rsp)
   );

   tdpt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (dividend),
      .div_rsp  (div_rsp)
   );

   // result register towards the rsp beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_res.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_res.load) begin
         rsp_prime_ff <= seq_res.is_prime;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-1){1'b0}}, rsp_prime_ff};

   // the sequencer never takes a number while it hands over a result
   `TDPT_ASSERT_NEVER(a_no_accept_on_load, clock, reset, req_tready && seq_res.load, "accept during load")
   // a taken number keeps the block busy for at least the next cycle
   `TDPT_ASSERT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "ready after accept")
   // a result only lands in a free output slot
   `TDPT_ASSERT(a_load_into_free, clock, reset, seq_res.load |-> (!rsp_tvalid || rsp_tready), "result overwritten")
   // a divider start from the idle sequencer never meets a division being reported
   `TDPT_ASSERT_NEVER(a_start_on_done, clock, reset, div_req.start && seq_idle && div_rsp.done, "start clash")

endmodule

[src/tdpt_divider.sv]
// restoring divider, one quotient bit per cycle
module tdpt_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  tdpt_pkg::div_req_type div_req,
   input  tdpt_pkg::number_type  dividend,
   output tdpt_pkg::div_rsp_type div_rsp
);
   import tdpt_pkg::*;

   number_type           acc_ff, acc_in;
   number_type           rem_ff, rem_in;
   number_type           dsr_ff;
   cnt_type              cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [NUMBER_BITS:0] trial;
   logic [NUMBER_BITS:0] diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, acc_ff[NUMBER_BITS-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      rem_in  = fits ? diff[NUMBER_BITS-1:0] : trial[NUMBER_BITS-1:0];
      acc_in  = {acc_ff[NUMBER_BITS-2:0], fits};
      cnt_in  = cnt_ff - cnt_type'(1);
      busy_in = busy_ff && (cnt_ff != '0);
      done_in = busy_ff && (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (div_req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_LAST;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (busy_ff) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         acc_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = acc_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[src/tdpt_sequencer.sv]
// sequencer stepping the 6k +/- 1 divisors through the shared divider
module tdpt_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  tdpt_pkg::number_type   number,
   output logic                   idle,
   input  logic                   slot_free,
   output tdpt_pkg::seq_res_type  seq_res,
   output tdpt_pkg::div_req_type  div_req,
   output tdpt_pkg::number_type   dividend,
   input  tdpt_pkg::div_rsp_type  div_rsp
);
   import tdpt_pkg::*;

   seq_state_type state_ff, state_in;
   number_type    n_ff, n_in;
   number_type    d_ff, d_in;
   logic          prime_ff, prime_in;
   logic          rem_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      prime_ff <= prime_in;
   end

   always_comb begin
      state_in        = state_ff;
      n_in            = n_ff;
      d_in            = d_ff;
      prime_in        = prime_ff;
      div_req.start   = 1'b0;
      div_req.divisor = TINY_PRIME;
      seq_res.load    = 1'b0;
      seq_res.is_prime = prime_ff;
      idle            = 1'b0;
      rem_zero        = (div_rsp.remainder == '0);
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               n_in = number;
               if (number <= SMALL_LIMIT) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else if (number <= TINY_PRIME) begin
                  prime_in = 1'b1;
                  state_in = ST_DONE;
               end else if (!number[0]) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  div_req.start   = 1'b1;
                  div_req.divisor = TINY_PRIME;
                  state_in        = ST_DIV3;
               end
            end
         end
         ST_DIV3: begin
            if (div_rsp.done) begin
               if (rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  d_in            = FIRST_DIVISOR;
                  div_req.start   = 1'b1;
                  div_req.divisor = FIRST_DIVISOR;
                  state_in        = ST_DIVD;
               end
            end
         end
         ST_DIVD: begin
            if (div_rsp.done) begin
               // bound d <= n / d taken from this division's quotient
               if (d_ff > div_rsp.quotient) begin
                  prime_in = 1'b1;
                  state_in = ST_DONE;
               end else if (rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  div_req.start   = 1'b1;
                  div_req.divisor = d_ff + PAIR_OFFSET;
                  state_in        = ST_DIVD2;
               end
            end
         end
         ST_DIVD2: begin
            if (div_rsp.done) begin
               if (rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  d_in            = d_ff + DIVISOR_STEP;
                  div_req.start   = 1'b1;
                  div_req.divisor = d_ff + DIVISOR_STEP;
                  state_in        = ST_DIVD;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               seq_res.load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the divider loads its dividend on the start edge, so the new number goes straight through
   assign dividend = n_in;

endmodule
